[design/isb_pkg.sv]
`timescale 1ns / 1ps
package isb_pkg;

    typedef enum logic [1:0] {
        RM_MEAN  = 2'd0,
        RM_SUM   = 2'd1,
        RM_COUNT = 2'd2,
        RM_ALT   = 2'd3
    } t_reduce;

    localparam logic [2:0] CFG_LOCUS_START = 3'd0;
    localparam logic [2:0] CFG_LOCUS_END   = 3'd1;
    localparam logic [2:0] CFG_BIN_WIDTH   = 3'd2;
    localparam logic [2:0] CFG_BINS_IN_USE = 3'd3;
    localparam logic [2:0] CFG_REDUCE_MODE = 3'd4;
    localparam logic [2:0] CFG_EMPTY_VALUE = 3'd5;

    localparam logic REQ_ACCUM = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    localparam int SUM_W = 48;
    localparam int CNT_W = 32;

    // Command handed from the front to the back: one bin range or one read.
    typedef struct packed {
        logic        is_read;
        logic [32:0] first;    // relative first bin
        logic [32:0] last;     // relative end bin, exclusive
        logic [31:0] value;
        logic [9:0]  sel;
    } t_cmd;

    typedef enum logic [2:0] {
        F_IDLE, F_DIV_S, F_DIV_E, F_DIV_B, F_PUSH
    } t_fstate;

    typedef enum logic [3:0] {
        B_IDLE, B_CLEAR, B_RD, B_WAIT, B_ACC, B_RDOUT, B_DIV, B_OUT
    } t_bstate;

endpackage

[design/isb_ram.sv]
`timescale 1ns / 1ps
module isb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[design/isb_front.sv]
`timescale 1ns / 1ps
module isb_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_req_type,
    input  logic [31:0]      i_start,
    input  logic [31:0]      i_end,
    input  logic [31:0]      i_value,
    input  logic [9:0]       i_sel,
    input  logic [31:0]      i_locus_start,
    input  logic [31:0]      i_locus_end,
    input  logic [23:0]      i_bin_width,
    output logic             o_push,
    output isb_pkg::t_cmd    o_cmd,
    input  logic             i_full
);
    isb_pkg::t_fstate r_state, n_state;
    logic [32:0] r_s, n_s, r_e, n_e, r_b, n_b;
    logic [32:0] r_num, n_num, r_q, n_q;
    logic [24:0] r_rem, n_rem;
    logic [5:0]  r_cnt, n_cnt;
    logic [1:0]  r_which, n_which;
    isb_pkg::t_cmd r_cmd, n_cmd;
    logic [23:0] w_bw;
    logic [25:0] w_trial;
    logic [24:0] w_shift;

    assign w_bw = (i_bin_width == 24'd0) ? 24'd1 : i_bin_width;
    assign w_shift = {r_rem[23:0], r_num[32]};
    assign w_trial = {1'b0, w_shift} - {2'b0, w_bw};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= isb_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_s <= n_s; r_e <= n_e; r_b <= n_b;
        r_num <= n_num; r_q <= n_q; r_rem <= n_rem;
        r_cnt <= n_cnt; r_which <= n_which; r_cmd <= n_cmd;
    end

    always_comb begin
        n_state = r_state; n_s = r_s; n_e = r_e; n_b = r_b;
        n_num = r_num; n_q = r_q; n_rem = r_rem; n_cnt = r_cnt;
        n_which = r_which; n_cmd = r_cmd;
        o_ready = 1'b0; o_push = 1'b0; o_cmd = r_cmd;
        unique case (r_state)
            isb_pkg::F_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_cmd.is_read = (i_req_type == isb_pkg::REQ_READ);
                    n_cmd.value = i_value;
                    n_cmd.sel = i_sel;
                    n_cmd.first = 33'd0;
                    n_cmd.last = 33'd0;
                    if (i_req_type == isb_pkg::REQ_READ) begin
                        n_state = isb_pkg::F_PUSH;
                    end else if (i_start < i_locus_end && i_end > i_locus_start) begin
                        n_s = {1'b0, (i_start > i_locus_start) ? i_start : i_locus_start};
                        n_e = {1'b0, (i_end < i_locus_end) ? i_end : i_locus_end};
                        n_num = {1'b0, i_locus_start};
                        n_rem = 25'd0; n_q = 33'd0; n_cnt = 6'd0;
                        n_state = isb_pkg::F_DIV_B;
                    end
                end
            end
            isb_pkg::F_DIV_B, isb_pkg::F_DIV_S, isb_pkg::F_DIV_E: begin
                // restoring divide, one bit a cycle
                if (!w_trial[25]) begin
                    n_rem = w_trial[24:0];
                    n_q = {r_q[31:0], 1'b1};
                end else begin
                    n_rem = w_shift;
                    n_q = {r_q[31:0], 1'b0};
                end
                n_num = {r_num[31:0], 1'b0};
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd32) begin
                    if (r_state == isb_pkg::F_DIV_B) begin
                        n_b = n_q; n_num = r_s; n_state = isb_pkg::F_DIV_S;
                    end else if (r_state == isb_pkg::F_DIV_S) begin
                        n_cmd.first = n_q - r_b;
                        n_num = r_e + {9'd0, w_bw} - 33'd1;
                        n_state = isb_pkg::F_DIV_E;
                    end else begin
                        // end bin below the locus base: empty range
                        n_cmd.last = (n_q < r_b) ? 33'd0 : n_q - r_b;
                        n_state = isb_pkg::F_PUSH;
                    end
                    n_cnt = 6'd0; n_rem = 25'd0; n_q = 33'd0;
                end
            end
            isb_pkg::F_PUSH: begin
                if (!i_full) begin
                    o_push = 1'b1;
                    n_state = isb_pkg::F_IDLE;
                end
            end
            default: n_state = isb_pkg::F_IDLE;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_push |-> !i_full)
        else $error("push into full queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> r_state == isb_pkg::F_IDLE) else $error("ready outside idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> r_state == isb_pkg::F_IDLE) else $error("push not closing item");
endmodule

[design/isb_queue.sv]
`timescale 1ns / 1ps
module isb_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  isb_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output isb_pkg::t_cmd o_cmd
);
    isb_pkg::t_cmd r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_n;
    assign o_full = (r_n == 2'd2);
    assign o_empty = (r_n == 2'd0);
    assign o_cmd = r_q[r_rp];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_n <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_n <= r_n + {1'b0, i_push} - {1'b0, i_pop};
        end
        if (i_push) r_q[r_wp] <= i_cmd;
    end
    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_pop |-> !o_empty)
        else $error("pop from empty queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_n != 2'd3)
        else $error("queue count overrun");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> !o_empty) else $error("queue lost entry");
endmodule

[design/isb_back.sv]
`timescale 1ns / 1ps
module isb_back #(
    parameter int BIN_DEPTH = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  isb_pkg::t_cmd i_cmd,
    output logic          o_pop,
    input  logic [10:0]   i_bins_in_use,
    input  logic [1:0]    i_reduce_mode,
    input  logic [31:0]   i_empty_value,
    output logic          o_busy,
    output logic          o_tvalid,
    input  logic          i_tready,
    output logic [9:0]    o_bin_index,
    output logic [31:0]   o_bin_result,
    output logic          o_bin_empty
);
    localparam int AW = (BIN_DEPTH > 1) ? $clog2(BIN_DEPTH) : 1;
    localparam int RW = isb_pkg::SUM_W + isb_pkg::CNT_W;
    localparam int QW = isb_pkg::SUM_W + 1;
    localparam logic signed [47:0] SMAX = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] SMIN = {1'b1, {47{1'b0}}};

    isb_pkg::t_bstate r_state, n_state;
    logic [AW:0]  r_clr, n_clr;
    logic [32:0]  r_idx, n_idx;
    logic [32:0]  r_last, n_last;
    logic [31:0]  r_val, n_val;
    logic [9:0]   r_sel, n_sel;
    logic         r_oob, n_oob;
    logic         r_neg, n_neg;
    logic [47:0]  r_num, n_num;
    logic [QW-1:0] r_q, n_q;
    logic [32:0]  r_rem, n_rem;
    logic [31:0]  r_cnt, n_cnt;
    logic [5:0]   r_step, n_step;
    logic         r_ov, n_ov;
    logic [31:0]  r_res, n_res;
    logic         r_emp, n_emp;
    logic [9:0]   r_oidx, n_oidx;
    logic         r_vld, n_vld;

    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [RW-1:0] w_wdata, w_rdata;
    logic signed [47:0] w_sum;
    logic [31:0]   w_c;
    logic signed [48:0] w_add;
    logic [11:0]   w_nb;
    logic [33:0]   w_trial;
    logic [32:0]   w_shift;
    logic [48:0]   w_mag;
    logic [63:0]   w_cq;

    isb_ram #(.WIDTH(RW), .DEPTH(BIN_DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata));

    assign w_sum = w_rdata[RW-1 -: 48];
    assign w_c   = w_rdata[31:0];
    assign w_add = {w_sum[47], w_sum} + {{17{r_val[31]}}, r_val};
    assign w_nb  = ({1'b0, i_bins_in_use} > BIN_DEPTH) ? 12'(BIN_DEPTH)
                                                       : {1'b0, i_bins_in_use};
    assign w_shift = {r_rem[31:0], r_num[47]};
    assign w_trial = {1'b0, w_shift} - {2'b0, r_cnt};
    assign w_mag = w_sum[47] ? 49'(-{w_sum[47], w_sum}) : {1'b0, w_sum};
    assign w_cq = {16'd0, w_c, 16'd0};
    assign o_busy = (r_state != isb_pkg::B_IDLE) || !i_empty || r_vld;
    assign o_tvalid = r_vld;
    assign o_bin_index = r_oidx;
    assign o_bin_result = r_res;
    assign o_bin_empty = r_emp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= isb_pkg::B_CLEAR; r_clr <= '0; r_vld <= 1'b0;
        end else begin
            r_state <= n_state; r_clr <= n_clr; r_vld <= n_vld;
        end
        r_idx <= n_idx; r_last <= n_last; r_val <= n_val; r_sel <= n_sel;
        r_oob <= n_oob; r_neg <= n_neg; r_num <= n_num; r_q <= n_q;
        r_rem <= n_rem; r_cnt <= n_cnt; r_step <= n_step; r_ov <= n_ov;
        r_res <= n_res; r_emp <= n_emp; r_oidx <= n_oidx;
    end

    always_comb begin
        n_state = r_state; n_clr = r_clr; n_idx = r_idx; n_last = r_last;
        n_val = r_val; n_sel = r_sel; n_oob = r_oob; n_neg = r_neg;
        n_num = r_num; n_q = r_q; n_rem = r_rem; n_cnt = r_cnt;
        n_step = r_step; n_ov = r_ov; n_res = r_res; n_emp = r_emp;
        n_oidx = r_oidx; n_vld = r_vld;
        o_pop = 1'b0; w_we = 1'b0;
        w_waddr = r_idx[AW-1:0]; w_raddr = r_idx[AW-1:0]; w_wdata = '0;
        if (r_vld && i_tready) n_vld = 1'b0;
        unique case (r_state)
            isb_pkg::B_CLEAR: begin
                w_we = 1'b1; w_waddr = r_clr[AW-1:0];
                n_clr = r_clr + 1'b1;
                if (r_clr == (AW+1)'(BIN_DEPTH - 1)) n_state = isb_pkg::B_IDLE;
            end
            isb_pkg::B_IDLE: begin
                if (!i_empty && !r_vld) begin
                    o_pop = 1'b1;
                    n_val = i_cmd.value; n_sel = i_cmd.sel;
                    if (i_cmd.is_read) begin
                        n_oob = ({22'd0, i_cmd.sel} >= BIN_DEPTH);
                        n_idx = {23'd0, i_cmd.sel};
                        n_state = isb_pkg::B_RD;
                    end else begin
                        n_oob = 1'b0;
                        n_idx = i_cmd.first; n_last = i_cmd.last;
                        n_state = isb_pkg::B_RD;
                    end
                    n_neg = i_cmd.is_read;
                end
            end
            isb_pkg::B_RD: begin
                // r_neg carries the read flag here
                if (!r_neg && (r_idx >= r_last || r_idx >= {21'd0, w_nb})) begin
                    n_state = isb_pkg::B_IDLE;
                end else begin
                    n_state = isb_pkg::B_WAIT;
                end
            end
            isb_pkg::B_WAIT: begin
                n_state = r_neg ? isb_pkg::B_RDOUT : isb_pkg::B_ACC;
            end
            isb_pkg::B_ACC: begin
                w_we = 1'b1;
                w_wdata[RW-1 -: 48] = (w_add > 49'(SMAX)) ? SMAX :
                                      (w_add < 49'(SMIN)) ? SMIN : w_add[47:0];
                w_wdata[31:0] = (w_c == '1) ? w_c : w_c + 32'd1;
                n_idx = r_idx + 33'd1;
                n_state = isb_pkg::B_RD;
            end
            isb_pkg::B_RDOUT: begin
                n_oidx = r_sel;
                n_emp = 1'b0;
                if (!r_oob) w_we = 1'b1;
                n_state = isb_pkg::B_OUT;
                if (r_oob || w_c == 32'd0) begin
                    n_res = i_empty_value; n_emp = 1'b1;
                end else if (i_reduce_mode == isb_pkg::RM_SUM) begin
                    n_res = (w_sum > 48'sh7FFFFFFF) ? 32'h7FFFFFFF :
                            (w_sum < -48'sh80000000) ? 32'h80000000 : w_sum[31:0];
                end else if (i_reduce_mode == isb_pkg::RM_COUNT) begin
                    n_res = (w_cq > 64'h7FFFFFFF) ? 32'h7FFFFFFF : w_cq[31:0];
                end else begin
                    // mean and alt modes: (|sum| + count/2) / count, one bit a cycle
                    n_neg = w_sum[47];
                    {n_ov, n_num} = w_mag + {18'd0, w_c[31:1]};
                    n_cnt = w_c; n_rem = 33'd0; n_q = '0; n_step = 6'd0;
                    n_state = isb_pkg::B_DIV;
                end
            end
            isb_pkg::B_DIV: begin
                // r_ov is bit 48 of the dividend, consumed first
                if (r_step == 6'd0) begin
                    n_rem = {32'd0, r_ov};
                    n_q = '0;
                    if ({32'd0, r_ov} >= {1'b0, r_cnt}) begin
                        n_rem = 33'd0; n_q = {{(QW-1){1'b0}}, 1'b1};
                    end
                end else begin
                    if (!w_trial[33]) begin
                        n_rem = w_trial[32:0]; n_q = {r_q[QW-2:0], 1'b1};
                    end else begin
                        n_rem = w_shift; n_q = {r_q[QW-2:0], 1'b0};
                    end
                    n_num = {r_num[46:0], 1'b0};
                end
                n_step = r_step + 6'd1;
                if (r_step == 6'd48) n_state = isb_pkg::B_OUT;
            end
            isb_pkg::B_OUT: begin
                if (!r_emp && (i_reduce_mode == isb_pkg::RM_MEAN ||
                               i_reduce_mode == isb_pkg::RM_ALT)) begin
                    if (r_neg) n_res = (r_q > 49'h80000000) ? 32'h80000000
                                                            : 32'(-r_q[31:0]);
                    else n_res = (r_q > 49'h7FFFFFFF) ? 32'h7FFFFFFF : r_q[31:0];
                end
                n_vld = 1'b1;
                n_state = isb_pkg::B_IDLE;
            end
            default: n_state = isb_pkg::B_IDLE;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && !i_tready) |=> r_vld) else $error("result dropped");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> r_state == isb_pkg::B_IDLE) else $error("pop while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == isb_pkg::B_OUT |=> r_vld) else $error("result not raised");
endmodule

[design/interval_signal_binner_top.sv]
`timescale 1ns / 1ps
// An accumulate runs three 33-step divides by bin width in the front, then
// walks each covered bin through B_RD, B_WAIT and B_ACC in the back.
// A read skips the divides; in the back, mean and alt modes add a B_DIV pass.
// Front and back overlap through a 2-entry command queue.
// Reset (i_rst_n low, synchronous) loads register defaults, then the back
// clears all BIN_DEPTH bins of the memory before taking commands.
module interval_signal_binner_top #(
    parameter int BIN_DEPTH = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: interval_start[31:0], interval_end[63:32], sample_value[95:64],
    //        bin_select[105:96], zero pad to 112
    input  logic [111:0] s_axis_tdata,
    // tuser: req_type
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: bin_index[9:0], bin_result[41:10], zero pad to 48
    output logic [47:0]  m_axis_tdata,
    // tuser: bin_empty
    output logic         m_axis_tuser,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);
    logic [31:0] r_locus_start, r_locus_end, r_empty_value;
    logic [23:0] r_bin_width;
    logic [10:0] r_bins_in_use;
    logic [1:0]  r_reduce_mode;
    logic        w_push, w_full, w_pop, w_qempty, w_busy;
    isb_pkg::t_cmd w_fcmd, w_bcmd;
    logic [9:0]  w_idx;
    logic [31:0] w_res;

    // Hold the configuration; write it only while no beat is in flight.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_locus_start <= '0; r_locus_end <= '0; r_bin_width <= 24'd1;
            r_bins_in_use <= 11'd1024; r_reduce_mode <= isb_pkg::RM_MEAN;
            r_empty_value <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                isb_pkg::CFG_LOCUS_START: r_locus_start <= i_cfg_data;
                isb_pkg::CFG_LOCUS_END:   r_locus_end <= i_cfg_data;
                isb_pkg::CFG_BIN_WIDTH:   r_bin_width <= i_cfg_data[23:0];
                isb_pkg::CFG_BINS_IN_USE: r_bins_in_use <= i_cfg_data[10:0];
                isb_pkg::CFG_REDUCE_MODE: r_reduce_mode <= i_cfg_data[1:0];
                isb_pkg::CFG_EMPTY_VALUE: r_empty_value <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Front: clip and divide into a relative bin range.
    isb_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_req_type(s_axis_tuser), .i_start(s_axis_tdata[31:0]),
        .i_end(s_axis_tdata[63:32]), .i_value(s_axis_tdata[95:64]),
        .i_sel(s_axis_tdata[105:96]),
        .i_locus_start(r_locus_start), .i_locus_end(r_locus_end),
        .i_bin_width(r_bin_width),
        .o_push(w_push), .o_cmd(w_fcmd), .i_full(w_full));

    isb_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_push), .i_cmd(w_fcmd),
        .o_full(w_full), .i_pop(w_pop), .o_empty(w_qempty), .o_cmd(w_bcmd));

    // Back: walk bins with read-modify-write, or read, reduce and clear.
    isb_back #(.BIN_DEPTH(BIN_DEPTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(w_qempty), .i_cmd(w_bcmd),
        .o_pop(w_pop), .i_bins_in_use(r_bins_in_use),
        .i_reduce_mode(r_reduce_mode), .i_empty_value(r_empty_value),
        .o_busy(w_busy), .o_tvalid(m_axis_tvalid), .i_tready(m_axis_tready),
        .o_bin_index(w_idx), .o_bin_result(w_res), .o_bin_empty(m_axis_tuser));

    assign m_axis_tdata = {6'd0, w_res, w_idx};

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> w_busy) else $error("queued command not seen by back");
endmodule

[tb/interval_signal_binner_top_tb.sv]
`timescale 1ns / 1ps
module interval_signal_binner_top_tb;

    localparam int DEPTH = 1024;
    // longest backlog: front + 2 queued + 1 running accumulate over 1024 bins
    localparam int SETTLE_CYCLES = 13000;
    localparam longint SUM_HI = 64'sd140737488355327;
    localparam longint SUM_LO = -64'sd140737488355328;

    typedef struct {
        bit        is_read;
        bit [31:0] iv_start;
        bit [31:0] iv_end;
        bit [31:0] value;
        bit [9:0]  sel;
    } t_req;

    typedef struct {
        bit [9:0]  idx;
        bit [31:0] res;
        bit        empty;
    } t_bin_out;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [47:0]  m_axis_tdata;
    logic         m_axis_tuser;
    logic         i_cfg_we;
    logic [2:0]   i_cfg_index;
    logic [31:0]  i_cfg_data;

    interval_signal_binner_top #(.BIN_DEPTH(DEPTH)) dut (.*);

    // Shadow of the block's registers and bin memory.
    bit [31:0] cfg_ls, cfg_le, cfg_empty;
    bit [23:0] cfg_bw;
    bit [10:0] cfg_nb;
    isb_pkg::t_reduce cfg_mode;
    longint    bin_sum_model[DEPTH];
    int unsigned bin_cnt_model[DEPTH];

    t_req     req_q[$];
    t_bin_out bin_out_q[$];
    t_req     cur_req;
    int       src_gap, snk_gap;
    bit       quiet;
    int       errors;

    always #5 i_clk = ~i_clk;

    function automatic bit [31:0] clamp_q16(longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    // Add one interval to every overlapped bin of the locus, up to the bins in use.
    function automatic void fold_interval(bit [31:0] s, bit [31:0] e, bit [31:0] v);
        longint unsigned ls, le, bw, nb, os, oe, b, b_end, base, idx;
        longint sm;
        ls = cfg_ls;
        le = cfg_le;
        bw = (cfg_bw == 0) ? 1 : cfg_bw;
        nb = (cfg_nb > DEPTH) ? DEPTH : cfg_nb;
        if (s >= le || e <= ls) return;
        os = (s > ls) ? s : ls;
        oe = (e < le) ? e : le;
        base = ls / bw;
        b_end = (oe + bw - 1) / bw;
        for (b = os / bw; b < b_end; b++) begin
            idx = b - base;
            if (idx >= nb) break;
            sm = bin_sum_model[idx] + longint'(signed'(v));
            if (sm > SUM_HI) sm = SUM_HI;
            if (sm < SUM_LO) sm = SUM_LO;
            bin_sum_model[idx] = sm;
            if (bin_cnt_model[idx] != 32'hFFFF_FFFF) bin_cnt_model[idx]++;
        end
    endfunction

    // Reduce one bin, then clear it.
    function automatic t_bin_out drain_bin(bit [9:0] sel);
        t_bin_out r;
        longint sm;
        longint unsigned mag, q, cnt;
        r.idx = sel;
        sm = bin_sum_model[sel];
        cnt = bin_cnt_model[sel];
        r.empty = (cnt == 0);
        if (cnt == 0) begin
            r.res = cfg_empty;
        end else if (cfg_mode == isb_pkg::RM_SUM) begin
            r.res = clamp_q16(sm);
        end else if (cfg_mode == isb_pkg::RM_COUNT) begin
            r.res = clamp_q16(longint'(cnt << 16));
        end else begin
            mag = (sm < 0) ? longint'(-sm) : longint'(sm);
            q = (mag + cnt / 2) / cnt;
            r.res = clamp_q16((sm < 0) ? -longint'(q) : longint'(q));
        end
        bin_sum_model[sel] = 0;
        bin_cnt_model[sel] = 0;
        return r;
    endfunction

    // Driver: predict on each accepted beat, then load the next one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (cur_req.is_read) bin_out_q.insert(bin_out_q.size(), drain_bin(cur_req.sel));
                else fold_interval(cur_req.iv_start, cur_req.iv_end, cur_req.value);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (req_q.size() > 0) begin
                    if (!quiet && $urandom_range(0, 9) == 0) begin
                        // hold off: drop valid and start a random gap
                        src_gap = $urandom_range(0, 3);
                        s_axis_tvalid <= 1'b0;
                    end else begin
                        cur_req = req_q.pop_front();
                        s_axis_tdata <= {6'd0, cur_req.sel, cur_req.value,
                                         cur_req.iv_end, cur_req.iv_start};
                        s_axis_tuser <= cur_req.is_read;
                        s_axis_tvalid <= 1'b1;
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Sink: stall the result side in short random bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (quiet) begin
            m_axis_tready <= 1'b1;
        end else if (snk_gap > 0) begin
            snk_gap--;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            snk_gap = $urandom_range(0, 3);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Monitor: compare each result beat with the oldest prediction.
    always @(posedge i_clk) begin
        t_bin_out want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (bin_out_q.size() == 0) begin
                $display("%0t: unexpected result beat idx=%0d res=%h empty=%b", $time,
                         m_axis_tdata[9:0], m_axis_tdata[41:10], m_axis_tuser);
                errors++;
            end else begin
                want = bin_out_q.pop_front();
                if (m_axis_tdata[9:0] !== want.idx) begin
                    $display("%0t: bin_index expected %0d actual %0d", $time,
                             want.idx, m_axis_tdata[9:0]);
                    errors++;
                end
                if (m_axis_tdata[41:10] !== want.res) begin
                    $display("%0t: bin_result (bin %0d) expected %h actual %h", $time,
                             want.idx, want.res, m_axis_tdata[41:10]);
                    errors++;
                end
                if (m_axis_tuser !== want.empty) begin
                    $display("%0t: bin_empty (bin %0d) expected %b actual %b", $time,
                             want.idx, want.empty, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            isb_pkg::CFG_LOCUS_START: cfg_ls = val;
            isb_pkg::CFG_LOCUS_END:   cfg_le = val;
            isb_pkg::CFG_BIN_WIDTH:   cfg_bw = val[23:0];
            isb_pkg::CFG_BINS_IN_USE: cfg_nb = val[10:0];
            isb_pkg::CFG_REDUCE_MODE: cfg_mode = isb_pkg::t_reduce'(val[1:0]);
            isb_pkg::CFG_EMPTY_VALUE: cfg_empty = val;
            default: ;
        endcase
    endtask

    task automatic load_config(bit [31:0] ls, bit [31:0] le, bit [23:0] bw,
                               bit [10:0] nb, isb_pkg::t_reduce mode, bit [31:0] ev);
        write_reg(isb_pkg::CFG_LOCUS_START, ls);
        write_reg(isb_pkg::CFG_LOCUS_END, le);
        write_reg(isb_pkg::CFG_BIN_WIDTH, {8'd0, bw});
        write_reg(isb_pkg::CFG_BINS_IN_USE, {21'd0, nb});
        write_reg(isb_pkg::CFG_REDUCE_MODE, {30'd0, mode});
        write_reg(isb_pkg::CFG_EMPTY_VALUE, ev);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_req(bit rd, bit [31:0] s, bit [31:0] e, bit [31:0] v, bit [9:0] sel);
        t_req r;
        r.is_read = rd;
        r.iv_start = s;
        r.iv_end = e;
        r.value = v;
        r.sel = sel;
        req_q.insert(req_q.size(), r);
    endtask

    // Random traffic aimed at the bins of the current locus.
    task automatic gen_traffic(int n);
        longint unsigned bw, nb, s, e;
        bit [31:0] v;
        for (int k = 0; k < n; k++) begin
            bw = (cfg_bw == 0) ? 1 : cfg_bw;
            nb = (cfg_nb > DEPTH) ? DEPTH : cfg_nb;
            case ($urandom_range(0, 7))
                0: v = 32'h7FFF_FFFF;
                1: v = 32'h8000_0000;
                2: v = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
                default: v = $urandom;
            endcase
            if ($urandom_range(0, 9) < 4) begin
                if ($urandom_range(0, 9) == 0)
                    push_req(isb_pkg::REQ_READ, $urandom, $urandom, $urandom, 10'($urandom));
                else
                    push_req(isb_pkg::REQ_READ, $urandom, $urandom, $urandom,
                             10'($urandom_range(0, (nb + 1 > 1023) ? 1023 : nb + 1)));
            end else if ($urandom_range(0, 19) == 0) begin
                // noise: arbitrary coordinates, possibly reversed or far away
                push_req(isb_pkg::REQ_ACCUM, $urandom, $urandom, v, 10'($urandom));
            end else begin
                s = longint'(cfg_ls) + $urandom_range(0, nb + 1) * bw
                    + $urandom_range(0, bw - 1) - $urandom_range(0, 1) * bw;
                e = s + $urandom_range(0, 3) * bw + $urandom_range(0, bw);
                if (s > 32'hFFFF_FFFF) s = 32'hFFFF_FFFF;
                if (e > 32'hFFFF_FFFF) e = 32'hFFFF_FFFF;
                push_req(isb_pkg::REQ_ACCUM, s[31:0], e[31:0], v, 10'($urandom));
            end
        end
    endtask

    // Wait until everything is sent and answered, then let a dropped-result
    // accumulate finish in the back before touching registers.
    task automatic drain_and_settle();
        do @(negedge i_clk);
        while (req_q.size() != 0 || s_axis_tvalid || bin_out_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        cfg_ls = 0;
        cfg_le = 0;
        cfg_bw = 1;
        cfg_nb = 1024;
        cfg_mode = isb_pkg::RM_MEAN;
        cfg_empty = 0;
        foreach (bin_sum_model[k]) begin
            bin_sum_model[k] = 0;
            bin_cnt_model[k] = 0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: small locus of 64 bins of width 5.
        load_config(32'd1000, 32'd1320, 24'd5, 11'd64, isb_pkg::RM_MEAN, 32'h8000_0000);
        push_req(isb_pkg::REQ_READ, 0, 0, 0, 10'd0);                       // empty bin
        push_req(isb_pkg::REQ_ACCUM, 32'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 10'd0); // whole locus
        push_req(isb_pkg::REQ_ACCUM, 32'd1002, 32'd1002, 32'h8000_0000, 10'h3FF); // zero length
        push_req(isb_pkg::REQ_ACCUM, 32'd1030, 32'd1010, 32'h0001_0000, 10'd0);   // reversed
        push_req(isb_pkg::REQ_ACCUM, 32'd2000, 32'd3000, 32'h0001_0000, 10'd0);  // past locus
        push_req(isb_pkg::REQ_ACCUM, 32'd0, 32'd1000, 32'h0001_0000, 10'd0);      // before locus
        push_req(isb_pkg::REQ_ACCUM, 32'd1007, 32'd1013, 32'hFFFF_8000, 10'd0);   // negative
        push_req(isb_pkg::REQ_ACCUM, 32'd1005, 32'd1006, 32'hFFFF_FFFF, 10'd0);
        push_req(isb_pkg::REQ_READ, 0, 0, 0, 10'd0);
        push_req(isb_pkg::REQ_READ, 0, 0, 0, 10'd1);
        push_req(isb_pkg::REQ_READ, 0, 0, 0, 10'd2);
        push_req(isb_pkg::REQ_READ, 0, 0, 0, 10'd63);
        push_req(isb_pkg::REQ_READ, 0, 0, 0, 10'd64);
        push_req(isb_pkg::REQ_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd1023);
        push_req(isb_pkg::REQ_READ, 0, 0, 0, 10'd3);
        gen_traffic(300);
        drain_and_settle();

        // Full coordinate range, unit bins, sum mode.
        load_config(32'd0, 32'hFFFF_FFFF, 24'd1, 11'd1024, isb_pkg::RM_SUM, 32'h7FFF_FFFF);
        push_req(isb_pkg::REQ_ACCUM, 32'd10, 32'd12, 32'h7FFF_FFFF, 10'd0);
        push_req(isb_pkg::REQ_ACCUM, 32'd10, 32'd12, 32'h7FFF_FFFF, 10'd0);
        push_req(isb_pkg::REQ_ACCUM, 32'd20, 32'd21, 32'h8000_0000, 10'd0);
        push_req(isb_pkg::REQ_ACCUM, 32'd20, 32'd21, 32'h8000_0000, 10'd0);
        push_req(isb_pkg::REQ_READ, 0, 0, 0, 10'd10);
        push_req(isb_pkg::REQ_READ, 0, 0, 0, 10'd20);
        gen_traffic(320);
        drain_and_settle();

        // Top of the coordinate space, widest bins, too many bins, count mode.
        load_config(32'hFFFF_0000, 32'hFFFF_FFFF, 24'hFF_FFFF, 11'd2047, isb_pkg::RM_COUNT,
                    $urandom);
        gen_traffic(320);
        drain_and_settle();

        // Zero width and zero bins: nothing accumulates, reads drain old bins.
        load_config($urandom, $urandom, 24'd0, 11'd0, isb_pkg::RM_ALT, $urandom);
        for (int k = 0; k < 60; k++) push_req(isb_pkg::REQ_READ, 0, 0, 0, 10'($urandom));
        gen_traffic(250);
        drain_and_settle();

        // Mean mode with the trailing bins in reach.
        load_config(32'd4096, 32'd4096 + 32'd128 * 3, 24'd3, 11'd128, isb_pkg::RM_MEAN,
                    32'h0000_0000);
        gen_traffic(320);
        drain_and_settle();

        // Random setting, no idling on either side.
        begin
            bit [31:0] ls;
            bit [23:0] bw;
            bit [10:0] nb;
            ls = $urandom;
            bw = $urandom_range(1, 64);
            nb = $urandom_range(1, 1024);
            load_config(ls, ls + $urandom_range(0, 32'd70000), bw, nb,
                        isb_pkg::t_reduce'($urandom_range(0, 3)), $urandom);
        end
        quiet = 1'b1;
        gen_traffic(360);
        drain_and_settle();

        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
